>>> rtl/masked_byte_pattern_scan_defines.svh
// Assertion macros for the pattern scan block
`ifndef MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH

`ifndef SYNTHESIS
`define MBPS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mbps assertion failed");
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mbps assertion failed");
`else
`define MBPS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/mbps_pkg.sv
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 48;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CARE_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_SELECT_INDEX   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              scan_start;
        logic              region_start;
        logic              scan_end;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    typedef struct packed {
        logic [7:0] pat_byte;
        logic       care;
        logic       active;
    } cell_cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic              scan_start;
        logic              scan_end;
        logic              fill_ok;
    } stage_t;

endpackage

>>> rtl/mbps_cell.sv
module mbps_cell (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  logic [7:0]            byte_in,
    input  mbps_pkg::cell_cfg_t   cell_cfg,
    output logic [7:0]            byte_out,
    output logic                  hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit = !cell_cfg.active || !cell_cfg.care || (byte_reg == cell_cfg.pat_byte);

endmodule

>>> rtl/masked_byte_pattern_scan.sv
// Path: each accepted item is registered in the byte cells, then any result in m_data.
// Throughput: one item per cycle when not stalled; the window is a row of byte cells
// shifted on every accepted item and compared in parallel in the following cycle.
// Stall: while a result waits for m_ready the compare stage holds and s_ready drops.
// Reset: aresetn (synchronous, active low) clears the config registers (length to 1),
// fill, match count and done mark, and empties the pipeline; no clearing pass.
`include "masked_byte_pattern_scan_defines.svh"

module masked_byte_pattern_scan (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mbps_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mbps_pkg::out_item_t               m_data,
    input  logic                              cfg_wen,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int PM     = mbps_pkg::PATTERN_MAX;
    localparam int IDX_W  = mbps_pkg::IDX_W;
    localparam int LEN_W  = mbps_pkg::LEN_W;
    localparam int ADDR_W = mbps_pkg::ADDR_W;
    localparam int CNT_W  = mbps_pkg::CNT_W;

    logic [63:0]                  pattern_low_reg;
    logic [63:0]                  pattern_high_reg;
    logic [mbps_pkg::CARE_W-1:0]  care_mask_reg;
    logic [LEN_W-1:0]             pattern_length_reg;
    logic [CNT_W-1:0]             select_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= LEN_W'(1);
            select_index_reg   <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                mbps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                mbps_pkg::CFG_CARE_MASK:      care_mask_reg      <= cfg_wdata[15:0];
                mbps_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                mbps_pkg::CFG_SELECT_INDEX:   select_index_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0]  len_used;
    logic [LEN_W-1:0]  len_less;
    logic [IDX_W-1:0]  len_m1;
    logic [127:0]      pattern_all;

    always_comb begin
        if (pattern_length_reg == '0) begin
            len_used = LEN_W'(1);
        end else if (pattern_length_reg > LEN_W'(PM)) begin
            len_used = LEN_W'(PM);
        end else begin
            len_used = pattern_length_reg;
        end
        len_less = len_used - LEN_W'(1);
        len_m1   = len_less[IDX_W-1:0];
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    logic in_fire;
    logic adv;
    logic stage_valid_reg;
    logic m_valid_reg;

    assign in_fire = s_valid && s_ready;
    assign adv     = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || adv;

    logic [7:0]          cell_bytes [PM];
    logic [PM-1:0]       cell_hits;
    mbps_pkg::cell_cfg_t cell_cfgs  [PM];

    for (genvar i = 0; i < PM; i++) begin : g_cell
        logic [IDX_W-1:0] pidx;
        logic [7:0]       byte_in;

        assign pidx = len_m1 - IDX_W'(i);
        assign cell_cfgs[i].active   = (IDX_W'(i) <= len_m1);
        assign cell_cfgs[i].pat_byte = pattern_all[{pidx, 3'b000} +: 8];
        assign cell_cfgs[i].care     = care_mask_reg[pidx];

        if (i == 0) begin : g_head
            assign byte_in = s_data.data_byte;
        end else begin : g_link
            assign byte_in = cell_bytes[i-1];
        end

        mbps_cell u_cell (
            .aclk     (aclk),
            .shift_en (in_fire),
            .byte_in  (byte_in),
            .cell_cfg (cell_cfgs[i]),
            .byte_out (cell_bytes[i]),
            .hit      (cell_hits[i])
        );
    end

    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_base;
    logic [LEN_W-1:0] fill_next;

    always_comb begin
        fill_base = (s_data.scan_start || s_data.region_start) ? '0 : fill_reg;
        fill_next = (fill_base == LEN_W'(PM)) ? fill_base : fill_base + LEN_W'(1);
    end

    mbps_pkg::stage_t stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                fill_reg        <= fill_next;
                stage_valid_reg <= 1'b1;
            end else if (adv) begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            stage_reg.byte_address <= s_data.byte_address;
            stage_reg.scan_start   <= s_data.scan_start;
            stage_reg.scan_end     <= s_data.scan_end;
            stage_reg.fill_ok      <= (fill_next >= len_used);
        end
    end

    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_base;
    logic             done_base;
    logic             is_match;
    logic             sel_hit;
    logic             end_hit;
    logic             result;

    always_comb begin
        count_base = stage_reg.scan_start ? '0 : count_reg;
        done_base  = stage_reg.scan_start ? 1'b0 : done_reg;
        is_match   = !done_base && stage_reg.fill_ok && (&cell_hits);
        sel_hit    = is_match && (count_base == select_index_reg);
        end_hit    = !done_base && !sel_hit && stage_reg.scan_end;
        result     = sel_hit || end_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                count_reg <= (is_match && !sel_hit) ? count_base + CNT_W'(1) : count_base;
                done_reg  <= done_base || result;
            end
            if (adv && result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && result) begin
            m_data.found         <= sel_hit;
            m_data.match_address <= sel_hit
                ? stage_reg.byte_address - ADDR_W'(len_m1) : '0;
        end
    end

    assign m_valid = m_valid_reg;

    `MBPS_ASSERT_SAME(a_not_found_zero, aclk, aresetn, m_valid && !m_data.found, m_data.match_address == '0)
    `MBPS_ASSERT_NEXT(a_result_sets_done, aclk, aresetn, adv && result, done_reg)
    `MBPS_ASSERT_SAME(a_done_silent, aclk, aresetn, adv && done_reg && !stage_reg.scan_start, !result)
    `MBPS_ASSERT_SAME(a_empty_ready, aclk, aresetn, !stage_valid_reg, s_ready)

endmodule
